[hdl/dmhq_pkg.sv]
// Shared types and constants for the d-ary min-heap queue.
`timescale 1ns / 1ps

package dmhq_pkg;

    localparam int OP_W     = 3;
    localparam int SCORE_W  = 32;
    localparam int TAG_W    = 32;
    localparam int TOTAL_W  = 7;
    localparam int STATUS_W = 2;
    localparam int ARITY_W  = 4;
    localparam int TDATA_W  = 72;
    localparam int TUSER_W  = 3;

    localparam logic [ARITY_W-1:0] ARITY_RESET = 4'd6;
    localparam int unsigned        MIN_ARITY   = 2;

    localparam logic [OP_W-1:0] OP_PUSH    = 3'd0;
    localparam logic [OP_W-1:0] OP_POP     = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_LT  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_LE  = 3'd3;
    localparam logic [OP_W-1:0] OP_PEEK    = 3'd4;
    localparam logic [OP_W-1:0] OP_CLEAR   = 3'd5;
    localparam logic [OP_W-1:0] OP_POP_ALL = 3'd6;

    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic [TAG_W-1:0]   tag;
    } t_entry;

    typedef struct packed {
        logic                found;
        logic [TAG_W-1:0]    tag;
        logic [SCORE_W-1:0]  score;
        logic [TOTAL_W-1:0]  total;
        logic [STATUS_W-1:0] status;
        logic                last;
    } t_result;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EMIT,
        S_UP_CHK,
        S_UP_DIV,
        S_UP_CMP,
        S_ROOT_RD,
        S_ROOT_CHK,
        S_LAST_RD,
        S_LAST_GOT,
        S_DN_LEVEL,
        S_DN_SCAN,
        S_DN_DEC
    } t_state;

endpackage

[hdl/dmhq_store.sv]
// Heap entry memory: one write port, one read port with registered data.
`timescale 1ns / 1ps

module dmhq_store #(
    parameter int DEPTH = 64,
    parameter int IDX_W = 6
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [IDX_W-1:0]  i_wr_addr,
    input  dmhq_pkg::t_entry  i_wr_data,
    input  logic [IDX_W-1:0]  i_rd_addr,
    output dmhq_pkg::t_entry  o_rd_data
);

    dmhq_pkg::t_entry r_mem [0:DEPTH-1];
    dmhq_pkg::t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

[hdl/dmhq_div.sv]
// Restoring divider, one quotient bit per cycle, for the parent index.
`timescale 1ns / 1ps

module dmhq_div #(
    parameter int NUM_W = 6,
    parameter int DEN_W = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [NUM_W-1:0] r_quot;

    logic [DEN_W:0]   rem_sh;
    logic [DEN_W:0]   diff;
    logic             ge;
    logic [NUM_W:0]   quot_sh;

    always_comb begin
        rem_sh  = {r_rem, r_quot[NUM_W-1]};
        diff    = rem_sh - {1'b0, r_den};
        ge      = (rem_sh >= {1'b0, r_den});
        quot_sh = {r_quot, ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_den  <= i_den;
            r_quot <= i_num;
        end else if (r_busy) begin
            r_rem  <= ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
            r_quot <= quot_sh[NUM_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

[hdl/dary_min_heap_queue.sv]
// Top level: d-ary min-heap priority queue with a stream in/out port.
`timescale 1ns / 1ps
// Operation: push climbs one level per parent divide and compare; pop sinks one level
//   per scan of the children; peek reads the root, while clear and rejects go straight
//   to the result. Pop-all-below repeats the pop loop per returned entry, each
//   behind a root check. One command at a time: a new one is taken only in idle;
//   the sift loop runs through one memory read port and one shared score comparator.
// Reset (sync, active low): entry count to zero, arity to 6; the entry memory is not
//   cleared, since only slots below the count are ever read. No clearing pass.

module dary_min_heap_queue #(
    parameter int CAPACITY  = 64,
    parameter int MAX_ARITY = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // arity register write
    input  logic                          i_cfg_wr_en,
    input  logic [dmhq_pkg::ARITY_W-1:0]  i_cfg_wr_data,
    // command beats
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // [2:0] operation, [34:3] item_score, [66:35] item_value, [71:67] zero
    input  logic [dmhq_pkg::TDATA_W-1:0]  s_axis_tdata,
    // result beats
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [31:0] out_value, [63:32] out_score, [70:64] entry_total, [71] zero
    output logic [dmhq_pkg::TDATA_W-1:0]  m_axis_tdata,
    // [0] found, [2:1] status
    output logic [dmhq_pkg::TUSER_W-1:0]  m_axis_tuser,
    output logic                          m_axis_tlast
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int AW    = $clog2(MAX_ARITY + 1);
    localparam int PW    = IDX_W + AW + 1;

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    dmhq_pkg::t_state                 r_state, n_state;
    dmhq_pkg::t_state                 r_ret,   n_ret;   // where S_EMIT goes next
    logic [dmhq_pkg::ARITY_W-1:0]     r_arity;
    logic [CNT_W-1:0]                 r_count;
    logic                             r_out_valid;
    dmhq_pkg::t_result                r_out;
    dmhq_pkg::t_result                r_res;            // result waiting for the slot
    logic [dmhq_pkg::OP_W-1:0]        r_op;
    logic [dmhq_pkg::SCORE_W-1:0]     r_bound;
    logic [IDX_W-1:0]                 r_pos;            // hole being moved
    logic [IDX_W-1:0]                 r_par;
    logic [dmhq_pkg::SCORE_W-1:0]     r_s;              // entry being sifted
    logic [dmhq_pkg::TAG_W-1:0]       r_t;
    logic [IDX_W-1:0]                 r_child;
    logic [IDX_W-1:0]                 r_end;
    logic                             r_scan_first;
    dmhq_pkg::t_entry                 r_best;
    logic [IDX_W-1:0]                 r_best_idx;
    dmhq_pkg::t_entry                 r_pend;           // pop-all: popped, not yet sent
    logic                             r_have_pend;

    // ---------------------------------------------------------------
    // Input fields and common terms
    // ---------------------------------------------------------------
    logic [dmhq_pkg::OP_W-1:0]    in_op;
    logic [dmhq_pkg::SCORE_W-1:0] in_score;
    logic [dmhq_pkg::TAG_W-1:0]   in_val;
    logic                         accept;
    logic                         slot_free;
    logic                         cnt_zero;
    logic                         cnt_full;
    logic [CNT_W-1:0]             count_m1;

    assign in_op     = s_axis_tdata[2:0];
    assign in_score  = s_axis_tdata[34:3];
    assign in_val    = s_axis_tdata[66:35];
    assign accept    = s_axis_tvalid && s_axis_tready;
    assign slot_free = !r_out_valid || m_axis_tready;
    assign cnt_zero  = (r_count == '0);
    assign cnt_full  = (r_count == CNT_W'(CAPACITY));
    assign count_m1  = r_count - 1'b1;

    // effective arity, saturated into MIN_ARITY..MAX_ARITY
    logic [7:0]    arity_ext;
    logic [7:0]    d_sat;
    logic [AW-1:0] eff_d;

    always_comb begin
        arity_ext = {4'b0, r_arity};
        if (arity_ext < 8'(dmhq_pkg::MIN_ARITY)) begin
            d_sat = 8'(dmhq_pkg::MIN_ARITY);
        end else if (arity_ext > 8'(MAX_ARITY)) begin
            d_sat = 8'(MAX_ARITY);
        end else begin
            d_sat = arity_ext;
        end
        eff_d = d_sat[AW-1:0];
    end

    // ---------------------------------------------------------------
    // Memory and divider
    // ---------------------------------------------------------------
    logic              mem_we;
    logic [IDX_W-1:0]  mem_wr_addr;
    dmhq_pkg::t_entry  mem_wr_data;
    logic [IDX_W-1:0]  mem_rd_addr;
    dmhq_pkg::t_entry  rd;

    dmhq_store #(
        .DEPTH (CAPACITY),
        .IDX_W (IDX_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_we      (mem_we),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (rd)
    );

    logic             div_start;
    logic             div_done;
    logic [IDX_W-1:0] div_quot;

    // parent of a slot is (pos - 1) / arity
    dmhq_div #(
        .NUM_W (IDX_W),
        .DEN_W (AW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_pos - 1'b1),
        .i_den   (eff_d),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // ---------------------------------------------------------------
    // Shared signed score comparator
    // ---------------------------------------------------------------
    logic [dmhq_pkg::SCORE_W-1:0] cmp_a, cmp_b;
    logic                         cmp_lt, cmp_le;

    always_comb begin
        unique case (r_state)
            dmhq_pkg::S_UP_CMP: begin
                cmp_a = rd.score;
                cmp_b = r_s;
            end
            dmhq_pkg::S_DN_SCAN: begin
                cmp_a = rd.score;
                cmp_b = r_best.score;
            end
            dmhq_pkg::S_DN_DEC: begin
                cmp_a = r_s;
                cmp_b = r_best.score;
            end
            default: begin
                cmp_a = rd.score;
                cmp_b = r_bound;
            end
        endcase
        cmp_lt = ($signed(cmp_a) < $signed(cmp_b));
        cmp_le = cmp_lt || (cmp_a == cmp_b);
    end

    // ---------------------------------------------------------------
    // Decision terms
    // ---------------------------------------------------------------
    logic             root_ok;     // root qualifies for the current pop
    logic             is_pop_all;
    dmhq_pkg::t_state done_st;     // after a sift-down finishes
    dmhq_pkg::t_state take_st;     // after the root is taken
    logic [PW-1:0]    prod;
    logic [PW-1:0]    first_c;
    logic [PW-1:0]    end_c;
    logic [PW-1:0]    last_idx;
    logic             is_leaf;
    logic             scan_end;

    always_comb begin
        is_pop_all = (r_op == dmhq_pkg::OP_POP_ALL);
        if (cnt_zero) begin
            root_ok = 1'b0;
        end else if (r_op == dmhq_pkg::OP_POP) begin
            root_ok = 1'b1;
        end else if (r_op == dmhq_pkg::OP_POP_LE) begin
            root_ok = cmp_le;
        end else begin
            root_ok = cmp_lt;
        end
        done_st  = is_pop_all ? dmhq_pkg::S_ROOT_RD : dmhq_pkg::S_IDLE;
        take_st  = (count_m1 == '0) ? done_st : dmhq_pkg::S_LAST_RD;
        prod     = PW'(r_pos) * PW'(eff_d);
        first_c  = prod + 1'b1;
        end_c    = prod + PW'(eff_d);
        last_idx = PW'(count_m1);
        is_leaf  = (first_c > last_idx);
        scan_end = (r_child == r_end);
    end

    // ---------------------------------------------------------------
    // Sequencer: next state
    // ---------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        unique case (r_state)
            dmhq_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = dmhq_pkg::S_EMIT;
                    n_ret   = dmhq_pkg::S_IDLE;
                    unique case (in_op) inside
                        dmhq_pkg::OP_PUSH: begin
                            if (!cnt_full) begin
                                n_state = dmhq_pkg::S_UP_CHK;
                            end
                        end
                        dmhq_pkg::OP_POP, dmhq_pkg::OP_POP_LT, dmhq_pkg::OP_POP_LE,
                        dmhq_pkg::OP_POP_ALL, dmhq_pkg::OP_PEEK: begin
                            if (!cnt_zero) begin
                                n_state = dmhq_pkg::S_ROOT_CHK;
                            end
                        end
                        default: begin
                            n_state = dmhq_pkg::S_EMIT;
                        end
                    endcase
                end
            end
            dmhq_pkg::S_EMIT: begin
                if (slot_free) begin
                    n_state = r_ret;
                end
            end
            dmhq_pkg::S_UP_CHK: begin
                if (r_pos == '0) begin
                    n_state = dmhq_pkg::S_EMIT;
                    n_ret   = dmhq_pkg::S_IDLE;
                end else begin
                    n_state = dmhq_pkg::S_UP_DIV;
                end
            end
            dmhq_pkg::S_UP_DIV: begin
                if (div_done) begin
                    n_state = dmhq_pkg::S_UP_CMP;
                end
            end
            dmhq_pkg::S_UP_CMP: begin
                if (cmp_le) begin
                    n_state = dmhq_pkg::S_EMIT;
                    n_ret   = dmhq_pkg::S_IDLE;
                end else begin
                    n_state = dmhq_pkg::S_UP_CHK;
                end
            end
            dmhq_pkg::S_ROOT_RD: begin
                n_state = dmhq_pkg::S_ROOT_CHK;
            end
            dmhq_pkg::S_ROOT_CHK: begin
                if (r_op == dmhq_pkg::OP_PEEK) begin
                    n_state = dmhq_pkg::S_EMIT;
                    n_ret   = dmhq_pkg::S_IDLE;
                end else if (root_ok) begin
                    if (!is_pop_all || r_have_pend) begin
                        n_state = dmhq_pkg::S_EMIT;
                        n_ret   = take_st;
                    end else begin
                        n_state = take_st;
                    end
                end else begin
                    n_state = dmhq_pkg::S_EMIT;
                    n_ret   = dmhq_pkg::S_IDLE;
                end
            end
            dmhq_pkg::S_LAST_RD: begin
                n_state = dmhq_pkg::S_LAST_GOT;
            end
            dmhq_pkg::S_LAST_GOT: begin
                if (r_count == CNT_W'(1)) begin
                    n_state = done_st;
                end else begin
                    n_state = dmhq_pkg::S_DN_LEVEL;
                end
            end
            dmhq_pkg::S_DN_LEVEL: begin
                n_state = is_leaf ? done_st : dmhq_pkg::S_DN_SCAN;
            end
            dmhq_pkg::S_DN_SCAN: begin
                if (scan_end) begin
                    n_state = dmhq_pkg::S_DN_DEC;
                end
            end
            dmhq_pkg::S_DN_DEC: begin
                n_state = cmp_le ? done_st : dmhq_pkg::S_DN_LEVEL;
            end
            default: begin
                n_state = dmhq_pkg::S_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Sequencer: memory and divider controls
    // ---------------------------------------------------------------
    always_comb begin
        mem_we      = 1'b0;
        mem_wr_addr = r_pos;
        mem_wr_data = '{score: r_s, tag: r_t};
        mem_rd_addr = '0;
        div_start   = 1'b0;
        unique case (r_state)
            dmhq_pkg::S_UP_CHK: begin
                if (r_pos == '0) begin
                    mem_we = 1'b1;
                end else begin
                    div_start = 1'b1;
                end
            end
            dmhq_pkg::S_UP_DIV: begin
                mem_rd_addr = div_quot;
            end
            dmhq_pkg::S_UP_CMP: begin
                mem_we = 1'b1;
                if (!cmp_le) begin
                    mem_wr_data = rd;
                end
            end
            dmhq_pkg::S_LAST_RD: begin
                mem_rd_addr = r_count[IDX_W-1:0];
            end
            dmhq_pkg::S_LAST_GOT: begin
                if (r_count == CNT_W'(1)) begin
                    mem_we      = 1'b1;
                    mem_wr_addr = '0;
                    mem_wr_data = rd;
                end
            end
            dmhq_pkg::S_DN_LEVEL: begin
                if (is_leaf) begin
                    mem_we = 1'b1;
                end else begin
                    mem_rd_addr = first_c[IDX_W-1:0];
                end
            end
            dmhq_pkg::S_DN_SCAN: begin
                mem_rd_addr = r_child + 1'b1;
            end
            dmhq_pkg::S_DN_DEC: begin
                mem_we = 1'b1;
                if (!cmp_le) begin
                    mem_wr_data = r_best;
                end
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Control registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dmhq_pkg::S_IDLE;
            r_ret       <= dmhq_pkg::S_IDLE;
            r_arity     <= dmhq_pkg::ARITY_RESET;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_have_pend <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            if (i_cfg_wr_en) begin
                r_arity <= i_cfg_wr_data;
            end
            if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == dmhq_pkg::S_EMIT && slot_free) begin
                r_out_valid <= 1'b1;
            end
            if (accept) begin
                r_have_pend <= 1'b0;
                if (in_op == dmhq_pkg::OP_PUSH && !cnt_full) begin
                    r_count <= r_count + 1'b1;
                end else if (in_op == dmhq_pkg::OP_CLEAR) begin
                    r_count <= '0;
                end
            end
            if (r_state == dmhq_pkg::S_ROOT_CHK && r_op != dmhq_pkg::OP_PEEK
                && root_ok) begin
                r_count     <= count_m1;
                r_have_pend <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------
    // Datapath registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (r_state == dmhq_pkg::S_EMIT && slot_free) begin
            r_out <= r_res;
        end
        unique case (r_state)
            dmhq_pkg::S_IDLE: begin
                if (accept) begin
                    r_op    <= in_op;
                    r_bound <= in_score;
                    r_pos   <= r_count[IDX_W-1:0];
                    r_s     <= in_score;
                    r_t     <= in_val;
                    r_res   <= '{found: 1'b0, tag: '0, score: '0,
                                 total: dmhq_pkg::TOTAL_W'(r_count),
                                 status: dmhq_pkg::STAT_OK, last: 1'b1};
                    unique case (in_op) inside
                        dmhq_pkg::OP_PUSH: begin
                            if (cnt_full) begin
                                r_res.status <= dmhq_pkg::STAT_FULL;
                            end
                        end
                        dmhq_pkg::OP_POP, dmhq_pkg::OP_POP_LT, dmhq_pkg::OP_POP_LE,
                        dmhq_pkg::OP_POP_ALL, dmhq_pkg::OP_PEEK: begin
                            r_res.status <= dmhq_pkg::STAT_EMPTY;
                        end
                        dmhq_pkg::OP_CLEAR: begin
                            r_res.total <= '0;
                        end
                        default: begin
                            r_res.status <= dmhq_pkg::STAT_OK;
                        end
                    endcase
                end
            end
            dmhq_pkg::S_UP_CHK: begin
                // push result once the entry has landed; count already bumped
                r_res <= '{found: 1'b0, tag: '0, score: '0,
                           total: dmhq_pkg::TOTAL_W'(r_count),
                           status: dmhq_pkg::STAT_OK, last: 1'b1};
            end
            dmhq_pkg::S_UP_DIV: begin
                r_par <= div_quot;
            end
            dmhq_pkg::S_UP_CMP: begin
                if (!cmp_le) begin
                    r_pos <= r_par;
                end
            end
            dmhq_pkg::S_ROOT_CHK: begin
                if (r_op == dmhq_pkg::OP_PEEK) begin
                    r_res <= '{found: 1'b1, tag: rd.tag, score: rd.score,
                               total: dmhq_pkg::TOTAL_W'(r_count),
                               status: dmhq_pkg::STAT_OK, last: 1'b1};
                end else if (root_ok) begin
                    r_pend <= rd;
                    if (!is_pop_all) begin
                        r_res <= '{found: 1'b1, tag: rd.tag, score: rd.score,
                                   total: dmhq_pkg::TOTAL_W'(count_m1),
                                   status: dmhq_pkg::STAT_OK, last: 1'b1};
                    end else begin
                        // the previous pop is not the final one
                        r_res <= '{found: 1'b1, tag: r_pend.tag, score: r_pend.score,
                                   total: dmhq_pkg::TOTAL_W'(r_count),
                                   status: dmhq_pkg::STAT_OK, last: 1'b0};
                    end
                end else if (r_have_pend) begin
                    r_res <= '{found: 1'b1, tag: r_pend.tag, score: r_pend.score,
                               total: dmhq_pkg::TOTAL_W'(r_count),
                               status: dmhq_pkg::STAT_OK, last: 1'b1};
                end else begin
                    r_res <= '{found: 1'b0, tag: '0, score: '0,
                               total: dmhq_pkg::TOTAL_W'(r_count),
                               status: dmhq_pkg::STAT_EMPTY, last: 1'b1};
                end
            end
            dmhq_pkg::S_LAST_GOT: begin
                r_s   <= rd.score;
                r_t   <= rd.tag;
                r_pos <= '0;
            end
            dmhq_pkg::S_DN_LEVEL: begin
                r_child      <= first_c[IDX_W-1:0];
                r_end        <= (end_c > last_idx) ? count_m1[IDX_W-1:0]
                                                   : end_c[IDX_W-1:0];
                r_scan_first <= 1'b1;
            end
            dmhq_pkg::S_DN_SCAN: begin
                // first child wins ties
                if (r_scan_first || cmp_lt) begin
                    r_best     <= rd;
                    r_best_idx <= r_child;
                end
                r_scan_first <= 1'b0;
                if (!scan_end) begin
                    r_child <= r_child + 1'b1;
                end
            end
            dmhq_pkg::S_DN_DEC: begin
                if (!cmp_le) begin
                    r_pos <= r_best_idx;
                end
            end
            default: begin
                r_par <= r_par;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Ports
    // ---------------------------------------------------------------
    assign s_axis_tready = (r_state == dmhq_pkg::S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out.total, r_out.score, r_out.tag};
    assign m_axis_tuser  = {r_out.status, r_out.found};
    assign m_axis_tlast  = r_out.last;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_div_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == dmhq_pkg::S_UP_DIV))
        else $error("divider finished outside the sift-up wait");

    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && in_op == dmhq_pkg::OP_PUSH && !cnt_full)
        |=> (r_count == CNT_W'($past(r_count) + 1'b1)))
        else $error("accepted push did not grow the heap");

    a_emit_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dmhq_pkg::S_EMIT && !slot_free) |=> (r_state == dmhq_pkg::S_EMIT))
        else $error("result dropped while output slot busy");

endmodule
